// ===== hdl/rkc_pkg.sv =====
// Shared types, constants and helpers for the RGBA clamped convolution unit.
// Depends on nothing; used by rgba_kernel_convolution_clamped_unit.
package rkc_pkg;

   localparam int MAX_WIDTH    = 64;
   localparam int MAX_HEIGHT   = 64;
   localparam int MAX_RADIUS   = 4;
   localparam int CHAN_MAX     = 255;

   localparam int COORD_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int FRAME_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int FRAME_AW     = COORD_W + ROW_W;
   localparam int KERNEL_DEPTH = 4 * MAX_RADIUS * MAX_RADIUS;
   localparam int KERNEL_AW    = $clog2(KERNEL_DEPTH);
   localparam int ACC_W        = 32;

   typedef enum logic [1:0] {
      KIND_WEIGHT = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_RADIUS = 2'd2,
      REG_NONE   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_DRAIN = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   // Clamp center plus a signed window offset into 0..lim-1.
   function automatic logic [5:0] clamp_coord(input logic [5:0] center,
                                              input logic signed [3:0] offset,
                                              input logic [6:0] lim);
      logic signed [7:0] sum;
      logic [6:0]        top;
      begin
         sum = $signed({2'b00, center}) + 8'(offset);
         top = lim - 7'd1;
         if (sum[7]) begin
            clamp_coord = 6'd0;
         end else if (sum[6:0] > top) begin
            clamp_coord = top[5:0];
         end else begin
            clamp_coord = sum[5:0];
         end
      end
   endfunction

   // Truncate a Q8.8 sum toward zero and saturate to 0..255.
   function automatic logic [7:0] finish_channel(input logic signed [ACC_W-1:0] sum);
      begin
         if (sum[ACC_W-1] || sum == '0) begin
            finish_channel = 8'd0;
         end else if (sum[ACC_W-1:8] > (ACC_W-8)'(CHAN_MAX)) begin
            finish_channel = 8'(CHAN_MAX);
         end else begin
            finish_channel = sum[15:8];
         end
      end
   endfunction

endpackage

// ===== hdl/rgba_kernel_convolution_clamped_unit.sv =====
// Top level of the RGBA clamp-to-edge convolution unit: frame and kernel
// memories, tap sequencer, shared four-lane multiply-accumulate, APB registers.
// Depends on rkc_pkg.
//
// Usage:
//  - Requests enter on the req_ ports and are taken at a rising edge where
//    start is high and busy is low. req_kind selects the request:
//    write a kernel weight, write a pixel, or query a filtered pixel.
//  - Weight and pixel writes land in memory at the accept edge and leave
//    busy low, so another request may follow in the next cycle.
//  - A query raises busy and walks the 2r x 2r window one tap per cycle
//    through one shared multiply-accumulate (four 8x16 channel lanes fed
//    by one frame read and one kernel read). Busy covers the tap walk, a
//    drain state that empties the read register and a done state that
//    finishes the sums. The result shows on the rsp_ ports for exactly
//    one cycle with rsp_valid high, in the first cycle with busy low again.
//  - The receiver cannot stall: rsp_ data is valid only while rsp_valid is
//    high and must be taken then. A new request may be taken in that cycle.
//  - Configuration goes through the APB port (frame_width at 0x0,
//    frame_height at 0x4, kernel_radius at 0x8), written only while idle.
//    Held values outside their range saturate to the nearest legal value.
//  - Reset (synchronous, active high) clears the sequencer and restores
//    64, 64 and 1 in the registers. Frame and kernel memories are not
//    cleared; read only entries that were written.
module rgba_kernel_convolution_clamped_unit (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_kind,
   input  logic [5:0]          req_weight_index,
   input  logic signed [15:0]  req_weight_value,
   input  logic [5:0]          req_pos_x,
   input  logic [5:0]          req_pos_y,
   input  logic [7:0]          req_in_red,
   input  logic [7:0]          req_in_green,
   input  logic [7:0]          req_in_blue,
   input  logic [7:0]          req_in_alpha,
   // result channel
   output logic                rsp_valid,
   output logic [7:0]          rsp_out_red,
   output logic [7:0]          rsp_out_green,
   output logic [7:0]          rsp_out_blue,
   output logic [7:0]          rsp_out_alpha,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [6:0] width_ff;
   logic [6:0] height_ff;
   logic [2:0] radius_ff;
   logic       csr_write;
   rkc_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_index = rkc_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'(rkc_pkg::MAX_WIDTH);
         height_ff <= 7'(rkc_pkg::MAX_HEIGHT);
         radius_ff <= 3'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            rkc_pkg::REG_WIDTH:  width_ff  <= pwdata[6:0];
            rkc_pkg::REG_HEIGHT: height_ff <= pwdata[6:0];
            rkc_pkg::REG_RADIUS: radius_ff <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rkc_pkg::REG_WIDTH:  prdata = {25'd0, width_ff};
         rkc_pkg::REG_HEIGHT: prdata = {25'd0, height_ff};
         rkc_pkg::REG_RADIUS: prdata = {29'd0, radius_ff};
         default:             prdata = 32'd0;
      endcase
   end

   // Saturate the registers into their legal ranges.
   logic [6:0] w_eff;
   logic [6:0] h_eff;
   logic [2:0] r_eff;

   always_comb begin
      if (width_ff == 7'd0) begin
         w_eff = 7'd1;
      end else if (width_ff > 7'(rkc_pkg::MAX_WIDTH)) begin
         w_eff = 7'(rkc_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == 7'd0) begin
         h_eff = 7'd1;
      end else if (height_ff > 7'(rkc_pkg::MAX_HEIGHT)) begin
         h_eff = 7'(rkc_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      if (radius_ff == 3'd0) begin
         r_eff = 3'd1;
      end else if (radius_ff > 3'(rkc_pkg::MAX_RADIUS)) begin
         r_eff = 3'(rkc_pkg::MAX_RADIUS);
      end else begin
         r_eff = radius_ff;
      end
   end

   // Window offset bounds: -r and r-1.
   logic signed [3:0] off_lo;
   logic signed [3:0] off_hi;
   assign off_lo = -$signed({1'b0, r_eff});
   assign off_hi = $signed({1'b0, r_eff}) - 4'sd1;

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   logic           accept;
   rkc_pkg::kind_type kind;
   logic           take_query;

   assign accept     = start && !busy;
   assign kind       = rkc_pkg::kind_type'(req_kind);
   assign take_query = accept && (kind == rkc_pkg::KIND_QUERY);

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   rkc_pkg::state_type state_ff;
   rkc_pkg::state_type state_in;

   logic signed [3:0]          off_i_ff;
   logic signed [3:0]          off_j_ff;
   logic [rkc_pkg::KERNEL_AW-1:0] kidx_ff;
   logic [5:0]                 cx_ff;
   logic [5:0]                 cy_ff;
   logic                       last_tap;
   logic                       issue;

   assign last_tap = (off_i_ff == off_hi) && (off_j_ff == off_hi);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rkc_pkg::ST_IDLE:  if (take_query) state_in = rkc_pkg::ST_RUN;
         rkc_pkg::ST_RUN:   if (last_tap) state_in = rkc_pkg::ST_DRAIN;
         rkc_pkg::ST_DRAIN: state_in = rkc_pkg::ST_DONE;
         rkc_pkg::ST_DONE:  state_in = rkc_pkg::ST_IDLE;
         default:           state_in = rkc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy  = (state_ff != rkc_pkg::ST_IDLE);
      issue = (state_ff == rkc_pkg::ST_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rkc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the clamped query center and step the window, row by row.
   always_ff @(posedge clock) begin
      if (take_query) begin
         cx_ff    <= rkc_pkg::clamp_coord(req_pos_x, 4'sd0, w_eff);
         cy_ff    <= rkc_pkg::clamp_coord(req_pos_y, 4'sd0, h_eff);
         off_i_ff <= off_lo;
         off_j_ff <= off_lo;
         kidx_ff  <= '0;
      end else if (issue) begin
         // kernel index 2r*(j+r)+(i+r) is simply the tap count
         kidx_ff <= kidx_ff + rkc_pkg::KERNEL_AW'(1);
         if (off_i_ff == off_hi) begin
            off_i_ff <= off_lo;
            off_j_ff <= off_j_ff + 4'sd1;
         end else begin
            off_i_ff <= off_i_ff + 4'sd1;
         end
      end
   end

   // Neighbor address, clamped to the frame edge.
   logic [5:0]                   nx;
   logic [5:0]                   ny;
   logic [rkc_pkg::FRAME_AW-1:0] rd_addr;

   assign nx      = rkc_pkg::clamp_coord(cx_ff, off_i_ff, w_eff);
   assign ny      = rkc_pkg::clamp_coord(cy_ff, off_j_ff, h_eff);
   assign rd_addr = {ny[rkc_pkg::ROW_W-1:0], nx[rkc_pkg::COORD_W-1:0]};

   // ---------------------------------------------------------------
   // Memories
   // ---------------------------------------------------------------
   logic [31:0] frame_mem [rkc_pkg::FRAME_DEPTH];
   logic [15:0] kernel_mem [rkc_pkg::KERNEL_DEPTH];
   logic [31:0] pix_ff;
   logic [15:0] wgt_ff;

   // Write ports: only when a write request is taken (never while busy).
   always_ff @(posedge clock) begin
      if (accept && kind == rkc_pkg::KIND_PIXEL) begin
         frame_mem[{req_pos_y[rkc_pkg::ROW_W-1:0], req_pos_x[rkc_pkg::COORD_W-1:0]}]
            <= {req_in_alpha, req_in_blue, req_in_green, req_in_red};
      end
      if (accept && kind == rkc_pkg::KIND_WEIGHT) begin
         kernel_mem[req_weight_index[rkc_pkg::KERNEL_AW-1:0]] <= req_weight_value;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      pix_ff <= frame_mem[rd_addr];
      wgt_ff <= kernel_mem[kidx_ff];
   end

   // ---------------------------------------------------------------
   // Shared multiply-accumulate, one tap per cycle, four channel lanes
   // ---------------------------------------------------------------
   logic                                mac_vld_ff;
   logic signed [rkc_pkg::ACC_W-1:0]    acc_ff [4];
   logic signed [24:0]                  prod [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod[k] = $signed({1'b0, pix_ff[8*k +: 8]}) * $signed(wgt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_vld_ff <= 1'b0;
      end else begin
         mac_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (take_query) begin
            acc_ff[k] <= '0;
         end else if (mac_vld_ff) begin
            acc_ff[k] <= acc_ff[k] + rkc_pkg::ACC_W'(prod[k]);
         end
      end
   end

   // ---------------------------------------------------------------
   // Result register: truncate, saturate, strobe for one cycle
   // ---------------------------------------------------------------
   logic       rsp_valid_ff;
   logic [7:0] red_ff;
   logic [7:0] green_ff;
   logic [7:0] blue_ff;
   logic [7:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == rkc_pkg::ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rkc_pkg::ST_DONE) begin
         red_ff   <= rkc_pkg::finish_channel(acc_ff[0]);
         green_ff <= rkc_pkg::finish_channel(acc_ff[1]);
         blue_ff  <= rkc_pkg::finish_channel(acc_ff[2]);
         alpha_ff <= rkc_pkg::finish_channel(acc_ff[3]);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_out_alpha = alpha_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == rkc_pkg::ST_DONE))
      else $error("result strobe without a finished query");

   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      take_query |=> busy)
      else $error("query taken but block not busy");

   a_mac_in_window: assert property (@(posedge clock) disable iff (reset)
      mac_vld_ff |-> (state_ff == rkc_pkg::ST_RUN || state_ff == rkc_pkg::ST_DRAIN))
      else $error("accumulate outside the tap walk");

   a_tap_count: assert property (@(posedge clock) disable iff (reset)
      (issue && last_tap) |->
         ({1'b0, kidx_ff} == 7'(4 * r_eff * r_eff) - 7'd1))
      else $error("kernel index does not match window size at last tap");

endmodule

// ===== tb/sv/rgba_kernel_convolution_clamped_unit_tb.sv =====
// Self-checking testbench for rgba_kernel_convolution_clamped_unit: a short table of
// directed requests, then random request streams under several register settings.
// Depends on rkc_pkg and the unit itself; reads no files.
module rgba_kernel_convolution_clamped_unit_tb;

   // One request as it goes out on the req_ ports.
   typedef struct {
      rkc_pkg::kind_type  kind;
      logic [5:0]         weight_index;
      logic signed [15:0] weight_value;
      logic [5:0]         pos_x;
      logic [5:0]         pos_y;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
   } request_type;

   // One filtered pixel as it comes back on the rsp_ ports.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   // A directed row; known marks a hand-written answer that overrides the predictor.
   typedef struct {
      request_type req;
      bit          known;
      rgba_type    want;
   } directed_row_type;

   // Register settings per random phase, raw as written (some out of range on purpose).
   localparam int NUM_PHASES = 8;
   localparam int PH_WIDTH  [NUM_PHASES] = '{8, 1, 64,   0, 127, 12,  5,  64};
   localparam int PH_HEIGHT [NUM_PHASES] = '{6, 1, 64, 100,   3,  9, 16,   2};
   localparam int PH_RADIUS [NUM_PHASES] = '{2, 1,  4,   0,   7,  3,  4,   2};
   localparam int PH_ITEMS  [NUM_PHASES] = '{200, 150, 150, 180, 180, 200, 200, 170};
   localparam int RANDOM_ITEMS = 1430;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_kind = '0;
   logic [5:0]         req_weight_index = '0;
   logic signed [15:0] req_weight_value = '0;
   logic [5:0]         req_pos_x = '0;
   logic [5:0]         req_pos_y = '0;
   logic [7:0]         req_in_red = '0;
   logic [7:0]         req_in_green = '0;
   logic [7:0]         req_in_blue = '0;
   logic [7:0]         req_in_alpha = '0;

   logic               rsp_valid;
   logic [7:0]         rsp_out_red;
   logic [7:0]         rsp_out_green;
   logic [7:0]         rsp_out_blue;
   logic [7:0]         rsp_out_alpha;

   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // Shadow of the unit: frame and kernel memories, plus written-entry flags so
   // that no query ever touches an entry the unit holds undefined.
   logic [31:0]        frame_mem [rkc_pkg::FRAME_DEPTH];
   logic signed [15:0] kernel_mem [rkc_pkg::KERNEL_DEPTH];
   bit                 frame_seen [rkc_pkg::FRAME_DEPTH];
   bit                 kernel_seen [rkc_pkg::KERNEL_DEPTH];
   logic [6:0]         width_reg = 7'd64;
   logic [6:0]         height_reg = 7'd64;
   logic [2:0]         radius_reg = 3'd1;

   rgba_type          pending_pixels [$];
   directed_row_type  directed_rows [$];
   int                idle_pct = 21;
   int                requests_sent = 0;
   int                pixels_compared = 0;
   int                errors = 0;

   rgba_kernel_convolution_clamped_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_in_red       (req_in_red),
      .req_in_green     (req_in_green),
      .req_in_blue      (req_in_blue),
      .req_in_alpha     (req_in_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the unit hangs or drops a result.
   initial begin
      #20_000_000;
      $display("[rgba_kernel_convolution_clamped_unit] ERROR");
      $finish;
   end

   // Registers hold raw low bits; the unit saturates them to the legal range on use.
   function automatic int eff_width();
      return (width_reg == 0) ? 1 :
             (width_reg > rkc_pkg::MAX_WIDTH) ? rkc_pkg::MAX_WIDTH : int'(width_reg);
   endfunction

   function automatic int eff_height();
      return (height_reg == 0) ? 1 :
             (height_reg > rkc_pkg::MAX_HEIGHT) ? rkc_pkg::MAX_HEIGHT : int'(height_reg);
   endfunction

   function automatic int eff_radius();
      return (radius_reg == 0) ? 1 :
             (radius_reg > rkc_pkg::MAX_RADIUS) ? rkc_pkg::MAX_RADIUS : int'(radius_reg);
   endfunction

   // Pin a coordinate to the frame edge.
   function automatic int clamp_to(input int c, input int lim);
      return (c < 0) ? 0 : (c > lim - 1) ? lim - 1 : c;
   endfunction

   // Filtered pixel at (qx,qy): clamp the center, sum weight times neighbor over
   // the 2r x 2r window, truncate the Q8.8 sums and saturate each channel to 0..255.
   function automatic rgba_type filter_pixel(input logic [5:0] qx, input logic [5:0] qy);
      int          w, h, r, cx, cy, nx, ny, i, j, k;
      longint      acc [4];
      logic [31:0] word;
      logic [7:0]  chan [4];
      w  = eff_width();
      h  = eff_height();
      r  = eff_radius();
      cx = clamp_to(int'(qx), w);
      cy = clamp_to(int'(qy), h);
      for (k = 0; k < 4; k++) acc[k] = 0;
      for (j = -r; j < r; j++) begin
         ny = clamp_to(cy + j, h);
         for (i = -r; i < r; i++) begin
            nx   = clamp_to(cx + i, w);
            word = frame_mem[ny * rkc_pkg::MAX_WIDTH + nx];
            for (k = 0; k < 4; k++)
               acc[k] += longint'(word[8*k +: 8])
                         * longint'(kernel_mem[2*r*(j + r) + (i + r)]);
         end
      end
      for (k = 0; k < 4; k++) begin
         if (acc[k] <= 0) chan[k] = 8'd0;
         else if (acc[k] / 256 > rkc_pkg::CHAN_MAX) chan[k] = 8'(rkc_pkg::CHAN_MAX);
         else chan[k] = 8'(acc[k] / 256);
      end
      return rgba_type'({chan[0], chan[1], chan[2], chan[3]});
   endfunction

   // Random request with all fields filled; positions and indices lean toward the
   // live frame and window, weights lean toward small values that do not saturate.
   function automatic request_type random_request();
      request_type rq;
      int          roll, w, h, r;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      rq.weight_index = ($urandom_range(3) == 0) ? 6'($urandom)
                                                 : 6'($urandom_range(4*r*r - 1));
      rq.weight_value = ($urandom_range(7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(64) - 24);
      rq.pos_x = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(w - 1));
      rq.pos_y = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(h - 1));
      rq.red   = 8'($urandom);
      rq.green = 8'($urandom);
      rq.blue  = 8'($urandom);
      rq.alpha = 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 40) rq.kind = rkc_pkg::KIND_QUERY;
      else if (roll < 70) rq.kind = rkc_pkg::KIND_PIXEL;
      else if (roll < 95) rq.kind = rkc_pkg::KIND_WEIGHT;
      else rq.kind = rkc_pkg::KIND_NONE;
      return rq;
   endfunction

   function automatic directed_row_type mk_row(input rkc_pkg::kind_type k, input int idx,
                                               input int wval, input int x, input int y,
                                               input logic [31:0] pix, input bit known,
                                               input logic [31:0] want);
      directed_row_type row;
      row.req.kind         = k;
      row.req.weight_index = 6'(idx);
      row.req.weight_value = 16'(wval);
      row.req.pos_x        = 6'(x);
      row.req.pos_y        = 6'(y);
      {row.req.red, row.req.green, row.req.blue, row.req.alpha} = pix;
      row.known = known;
      row.want  = rgba_type'(want);
      return row;
   endfunction

   // Present a request, hold it until the unit takes it, then update the shadow
   // state and queue the expected pixel for a query. Idle the sender afterwards
   // at the current rate, one cycle at a time.
   task automatic issue(input request_type rq, input bit known, input rgba_type want);
      start            <= 1'b1;
      req_kind         <= rq.kind;
      req_weight_index <= rq.weight_index;
      req_weight_value <= rq.weight_value;
      req_pos_x        <= rq.pos_x;
      req_pos_y        <= rq.pos_y;
      req_in_red       <= rq.red;
      req_in_green     <= rq.green;
      req_in_blue      <= rq.blue;
      req_in_alpha     <= rq.alpha;
      do @(posedge clock); while (busy);
      case (rq.kind)
         rkc_pkg::KIND_WEIGHT: begin
            kernel_mem[rq.weight_index]  = rq.weight_value;
            kernel_seen[rq.weight_index] = 1'b1;
         end
         rkc_pkg::KIND_PIXEL: begin
            frame_mem[{rq.pos_y, rq.pos_x}]  = {rq.alpha, rq.blue, rq.green, rq.red};
            frame_seen[{rq.pos_y, rq.pos_x}] = 1'b1;
         end
         rkc_pkg::KIND_QUERY: begin
            pending_pixels.push_back(known ? want : filter_pixel(rq.pos_x, rq.pos_y));
         end
         default: begin
         end
      endcase
      // every taken request counts, ignored kinds included
      requests_sent++;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Write every kernel entry and neighbor pixel the query will read but that
   // nothing has written yet.
   task automatic prime_window(input logic [5:0] qx, input logic [5:0] qy);
      int          w, h, r, cx, cy, nx, ny, i, j, k;
      request_type fill;
      w  = eff_width();
      h  = eff_height();
      r  = eff_radius();
      cx = clamp_to(int'(qx), w);
      cy = clamp_to(int'(qy), h);
      for (k = 0; k < 4*r*r; k++) begin
         if (!kernel_seen[k]) begin
            fill              = random_request();
            fill.kind         = rkc_pkg::KIND_WEIGHT;
            fill.weight_index = 6'(k);
            issue(fill, 1'b0, '0);
         end
      end
      for (j = -r; j < r; j++) begin
         for (i = -r; i < r; i++) begin
            ny = clamp_to(cy + j, h);
            nx = clamp_to(cx + i, w);
            if (!frame_seen[ny * rkc_pkg::MAX_WIDTH + nx]) begin
               fill       = random_request();
               fill.kind  = rkc_pkg::KIND_PIXEL;
               fill.pos_x = 6'(nx);
               fill.pos_y = 6'(ny);
               issue(fill, 1'b0, '0);
            end
         end
      end
   endtask

   // Setup cycle, then access cycle; the write lands on the edge with pready high.
   task automatic csr_write(input rkc_pkg::reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         rkc_pkg::REG_WIDTH:  width_reg  = value[6:0];
         rkc_pkg::REG_HEIGHT: height_reg = value[6:0];
         rkc_pkg::REG_RADIUS: radius_reg = value[2:0];
         default: begin
         end
      endcase
   endtask

   // Drain all outstanding pixels, then let the pipeline settle before touching
   // the registers or ending the run.
   task automatic drain(input int pause);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Results cannot be held off: take each one in the single cycle its strobe is up
   // and compare it with the oldest queued pixel.
   always @(posedge clock) begin
      rgba_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d", $time,
                     rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            check_chan("red",   want.red,   rsp_out_red);
            check_chan("green", want.green, rsp_out_green);
            check_chan("blue",  want.blue,  rsp_out_blue);
            check_chan("alpha", want.alpha, rsp_out_alpha);
            pixels_compared++;
         end
      end
   end

   initial begin
      int          row_i, ph, phase_end, rand_done;
      request_type rq;

      // Directed rows run at the reset setting: 64 x 64 frame, radius 1, so a query
      // reads kernel entries 0..3 and at most the 2 x 2 block with the center at its lower right.
      directed_rows = '{
         mk_row(rkc_pkg::KIND_WEIGHT, 0, 16'h0100, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_WEIGHT, 1, 16'h0100, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_WEIGHT, 2, 16'h0100, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_WEIGHT, 3, 16'h0100, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_PIXEL,  0, 0, 0, 0, 32'hFF00_8001, 1'b0, 32'h0),
         // corner query: every tap clamps to (0,0), unit weights sum four copies
         mk_row(rkc_pkg::KIND_QUERY,  0, 0, 0, 0, 32'h0, 1'b1, 32'hFF00_FF04),
         // most negative weight drives every nonzero channel below zero
         mk_row(rkc_pkg::KIND_WEIGHT, 0, 16'h8000, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_QUERY,  0, 0, 0, 0, 32'h0, 1'b1, 32'h0000_0000),
         mk_row(rkc_pkg::KIND_WEIGHT, 0, 16'h7FFF, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_QUERY,  0, 0, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_PIXEL,  0, 0, 63, 63, 32'hFFFF_FFFF, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_PIXEL,  0, 0, 62, 63, 32'h0000_0000, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_PIXEL,  0, 0, 63, 62, 32'hFF00_FF00, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_PIXEL,  0, 0, 62, 62, 32'h00FF_00FF, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_WEIGHT, 0, 16'h0040, 0, 0, 32'h0, 1'b0, 32'h0),
         // unknown kind must leave kernel and frame alone
         mk_row(rkc_pkg::KIND_NONE,   0, 16'h7FFF, 63, 63, 32'h0000_0000, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_QUERY,  0, 0, 63, 63, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_WEIGHT, 3, 16'hFFFF, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_WEIGHT, 1, 16'h0000, 0, 0, 32'h0, 1'b0, 32'h0),
         mk_row(rkc_pkg::KIND_WEIGHT, 2, 16'h0000, 0, 0, 32'h0, 1'b0, 32'h0),
         // fractional sums truncate toward zero
         mk_row(rkc_pkg::KIND_QUERY,  0, 0, 63, 63, 32'h0, 1'b0, 32'h0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (row_i = 0; row_i < directed_rows.size(); row_i++)
         issue(directed_rows[row_i].req, directed_rows[row_i].known,
               directed_rows[row_i].want);

      // Random phases: reprogram the registers while idle, then stream requests.
      // Queries are preceded by the writes they need; the sender idles 21 in a
      // hundred for the first third, 74 for the second, never for the last.
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain(10);
         csr_write(rkc_pkg::REG_WIDTH,  32'(PH_WIDTH[ph]));
         csr_write(rkc_pkg::REG_HEIGHT, 32'(PH_HEIGHT[ph]));
         csr_write(rkc_pkg::REG_RADIUS, 32'(PH_RADIUS[ph]));
         if (ph == 0) csr_write(rkc_pkg::REG_NONE, 32'h0000_0005);
         phase_end = requests_sent + PH_ITEMS[ph];
         while (requests_sent < phase_end) begin
            rand_done = requests_sent - directed_rows.size();
            idle_pct  = (rand_done < RANDOM_ITEMS / 3)     ? 21 :
                        (rand_done < 2 * RANDOM_ITEMS / 3) ? 74 : 0;
            rq = random_request();
            if (rq.kind == rkc_pkg::KIND_QUERY) prime_window(rq.pos_x, rq.pos_y);
            issue(rq, 1'b0, '0);
         end
      end

      // Drop start, wait out every pixel in flight plus one full radius-4 query.
      drain(80);
      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d expected pixels never arrived", $time, pending_pixels.size());
         errors += pending_pixels.size();
      end

      $display("Sent %0d requests over %0d register settings; compared %0d filtered pixels.",
               requests_sent, NUM_PHASES + 1, pixels_compared);
      if (errors == 0) begin
         $display("[rgba_kernel_convolution_clamped_unit] OK");
      end else begin
         $display("[rgba_kernel_convolution_clamped_unit] ERROR");
      end
      $finish;
   end

endmodule
